### rtl/hsj_pkg.sv
// shared types, constants and helper functions for the halton sub-pixel jitter block
`default_nettype none

package hsj_pkg;

  // default parameter values
  localparam int DEF_MAX_PHASES = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // fixed field widths
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;
  localparam int FC_W      = 64;
  localparam int JIT_W     = 16;
  localparam int PT_W      = 9;

  // phase count division widths: width squared, and 8 * width squared plus rounding
  localparam int SQ_W  = 2 * CFG_W;
  localparam int NUM_W = SQ_W + 4;

  // frame counter bits consumed per modulo step
  localparam int MOD_BITS_PER_STEP = 2;
  localparam int MOD_STEPS         = FC_W / MOD_BITS_PER_STEP;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RENDER_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 15'd1920;

  // divide by three through a reciprocal, exact for every 13-bit input
  localparam int               DIV3_W     = 13;
  localparam int               DIV3_SHIFT = 17;
  localparam logic [16:0]      DIV3_RECIP = 17'd43691;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic sq;
    logic pdiv_init;
    logic pdiv_step;
    logic pdiv_fin;
    logic mod_step;
    logic dig_init;
    logic dig_step;
    logic frac_init;
    logic frac_step;
    logic out_load;
  } hsj_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic phase_ok;
    logic dig_done;
  } hsj_sts_t;

  function automatic logic [DIV3_W-1:0] div3(input logic [DIV3_W-1:0] x);
    logic [DIV3_W+DIV3_SHIFT-1:0] prod;
    prod = (DIV3_W + DIV3_SHIFT)'(x) * (DIV3_W + DIV3_SHIFT)'(DIV3_RECIP);
    return prod[DIV3_SHIFT +: DIV3_W];
  endfunction

endpackage

`default_nettype wire

### rtl/halton_subpixel_jitter.sv
// top level of the halton (2,3) sub-pixel jitter generator
// Usage:
//   input channel: frame_counter with in_valid / in_stall; a word is taken when
//   in_valid is high and in_stall is low. One word is worked on at a time.
//   output channel: jitter_x, jitter_y (signed, 2^-FRAC_BITS pixel units),
//   phase_total and phase_clamped with out_valid / out_stall.
//   config channel: cfg_index 0 = render width, 1 = display width, written on
//   cfg_valid && cfg_ready; write only while the block is idle.
// Sequence: an accepted word runs 32 modulo steps (two frame counter bits
//   per cycle), one to nine digit steps, FRAC_BITS fraction steps and the
//   output load. The first word after reset or a config write first runs
//   the phase count division (34 steps), whose result is then kept. The
//   next word can be taken the cycle after the result is loaded.
// The result sits in an output register; the next word is accepted while it
//   waits. If out_stall holds, the finished next result waits in the datapath
//   until the register frees.
// Reset: synchronous; both widths return to 1920, the phase count is
//   recomputed, out_valid clears, and in_stall / cfg_ready hold during reset.
`default_nettype none

module halton_subpixel_jitter #(
  parameter int MAX_PHASES = hsj_pkg::DEF_MAX_PHASES,
  parameter int FRAC_BITS  = hsj_pkg::DEF_FRAC_BITS
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [hsj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [hsj_pkg::CFG_W-1:0]         cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [hsj_pkg::FC_W-1:0]          frame_counter,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [hsj_pkg::JIT_W-1:0]  jitter_x,
  output logic signed [hsj_pkg::JIT_W-1:0]  jitter_y,
  output logic [hsj_pkg::PT_W-1:0]          phase_total,
  output logic                              phase_clamped
);

  hsj_pkg::hsj_cmd_t cmd;
  hsj_pkg::hsj_sts_t sts;

  // sequencer
  hsj_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and registers
  hsj_dp #(
    .MAX_PHASES (MAX_PHASES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .frame_counter (frame_counter),
    .cmd           (cmd),
    .sts           (sts),
    .jitter_x      (jitter_x),
    .jitter_y      (jitter_y),
    .phase_total   (phase_total),
    .phase_clamped (phase_clamped)
  );

endmodule

`default_nettype wire

### rtl/hsj_dp.sv
// datapath: config registers, phase count divider, frame modulo, digit loops and fraction divider
`default_nettype none

module hsj_dp #(
  parameter int MAX_PHASES = hsj_pkg::DEF_MAX_PHASES,
  parameter int FRAC_BITS  = hsj_pkg::DEF_FRAC_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [hsj_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [hsj_pkg::CFG_W-1:0]            cfg_data,
  input  wire  [hsj_pkg::FC_W-1:0]             frame_counter,
  input  wire  hsj_pkg::hsj_cmd_t              cmd,
  output hsj_pkg::hsj_sts_t                    sts,
  output logic signed [hsj_pkg::JIT_W-1:0]     jitter_x,
  output logic signed [hsj_pkg::JIT_W-1:0]     jitter_y,
  output logic [hsj_pkg::PT_W-1:0]             phase_total,
  output logic                                 phase_clamped
);

  localparam int PW = $clog2(MAX_PHASES + 1);
  localparam int DW = PW + 2;
  localparam int JW = (FRAC_BITS > hsj_pkg::JIT_W) ? FRAC_BITS : hsj_pkg::JIT_W;
  localparam logic [JW-1:0] HALF = JW'(1) << (FRAC_BITS - 1);

  localparam int CW = hsj_pkg::CFG_W;
  localparam int SW = hsj_pkg::SQ_W;
  localparam int NW = hsj_pkg::NUM_W;
  localparam int FW = hsj_pkg::FC_W;

  logic [CW-1:0]        render_width;
  logic [CW-1:0]        display_width;
  logic                 phase_ok;
  logic [SW-1:0]        rsq;
  logic [SW-1:0]        dsq;
  logic [NW-1:0]        pdvd;
  logic [SW-1:0]        prem;
  logic [PW-1:0]        phases;
  logic                 clamped;
  logic [FW-1:0]        fc;
  logic [PW-1:0]        mrem;
  logic [PW-1:0]        i2;
  logic [PW-1:0]        i3;
  logic [DW-1:0]        rev2;
  logic [DW-1:0]        rev3;
  logic [DW-1:0]        den2;
  logic [DW-1:0]        den3;
  logic [DW-1:0]        fr2;
  logic [DW-1:0]        fr3;
  logic [FRAC_BITS-1:0] q2;
  logic [FRAC_BITS-1:0] q3;

  logic                 cfg_wr;
  logic [SW:0]          pshift;
  logic                 pbit;
  logic [SW-1:0]        prem_next;
  logic                 clamp_next;
  logic [PW-1:0]        phases_next;
  logic [PW:0]          ms1;
  logic [PW-1:0]        ms1r;
  logic [PW:0]          ms2;
  logic [PW-1:0]        mrem_next;
  logic [PW-1:0]        idx;
  logic [hsj_pkg::DIV3_W-1:0] i3_quot;
  logic [hsj_pkg::DIV3_W-1:0] i3_rest;
  logic [1:0]           dig3;
  logic [DW:0]          ft2;
  logic [DW:0]          ft3;
  logic                 fb2;
  logic                 fb3;
  logic [JW-1:0]        jx_full;
  logic [JW-1:0]        jy_full;

  assign cfg_ready = !rst;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign sts.phase_ok = phase_ok;
  assign sts.dig_done = (i2 == '0) && (i3 == '0);

  // configuration registers and phase cache flag
  always_ff @(posedge clk) begin
    if (rst) begin
      render_width  <= hsj_pkg::WIDTH_RESET;
      display_width <= hsj_pkg::WIDTH_RESET;
      phase_ok      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        hsj_pkg::CFG_RENDER_WIDTH:  render_width  <= cfg_data;
        hsj_pkg::CFG_DISPLAY_WIDTH: display_width <= cfg_data;
        default: ;
      endcase
      phase_ok <= 1'b0;
    end else if (cmd.pdiv_fin) begin
      phase_ok <= 1'b1;
    end
  end

  // phase count divider step, one quotient bit per cycle
  always_comb begin
    pshift = {prem, pdvd[NW-1]};
    pbit   = (pshift >= {1'b0, rsq});
    prem_next = pbit ? SW'(pshift - {1'b0, rsq}) : pshift[SW-1:0];
  end

  // clamp and floor of the phase count
  always_comb begin
    clamp_next = (render_width == '0) || (pdvd > NW'(MAX_PHASES));
    if (clamp_next) begin
      phases_next = PW'(MAX_PHASES);
    end else if (pdvd == '0) begin
      phases_next = PW'(1);
    end else begin
      phases_next = pdvd[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      rsq <= SW'(render_width) * SW'(render_width);
      dsq <= SW'(display_width) * SW'(display_width);
    end
    if (cmd.pdiv_init) begin
      pdvd <= {dsq, 3'b000} + NW'(rsq) - NW'(1);
      prem <= '0;
    end else if (cmd.pdiv_step) begin
      pdvd <= {pdvd[NW-2:0], pbit};
      prem <= prem_next;
    end
    if (cmd.pdiv_fin) begin
      phases  <= phases_next;
      clamped <= clamp_next;
    end
  end

  // frame modulo, two dividend bits per cycle
  always_comb begin
    ms1  = {mrem, fc[FW-1]};
    ms1r = (ms1 >= {1'b0, phases}) ? PW'(ms1 - {1'b0, phases}) : ms1[PW-1:0];
    ms2  = {ms1r, fc[FW-2]};
    mrem_next = (ms2 >= {1'b0, phases}) ? PW'(ms2 - {1'b0, phases}) : ms2[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fc   <= frame_counter;
      mrem <= '0;
    end else if (cmd.mod_step) begin
      fc   <= {fc[FW-3:0], 2'b00};
      mrem <= mrem_next;
    end
  end

  // base 2 and base 3 digit reversal
  assign idx     = mrem + PW'(1);
  assign i3_quot = hsj_pkg::div3(hsj_pkg::DIV3_W'(i3));
  assign i3_rest = hsj_pkg::DIV3_W'(i3) - ((i3_quot << 1) + i3_quot);
  assign dig3    = i3_rest[1:0];

  always_ff @(posedge clk) begin
    if (cmd.dig_init) begin
      i2   <= idx;
      i3   <= idx;
      rev2 <= '0;
      rev3 <= '0;
      den2 <= DW'(1);
      den3 <= DW'(1);
    end else if (cmd.dig_step) begin
      if (i2 != '0) begin
        i2   <= i2 >> 1;
        rev2 <= {rev2[DW-2:0], i2[0]};
        den2 <= {den2[DW-2:0], 1'b0};
      end
      if (i3 != '0) begin
        i3   <= PW'(i3_quot);
        rev3 <= (rev3 << 1) + rev3 + DW'(dig3);
        den3 <= (den3 << 1) + den3;
      end
    end
  end

  // fraction division, one result bit per cycle for each base
  always_comb begin
    ft2 = {fr2, 1'b0};
    ft3 = {fr3, 1'b0};
    fb2 = (ft2 >= {1'b0, den2});
    fb3 = (ft3 >= {1'b0, den3});
  end

  always_ff @(posedge clk) begin
    if (cmd.frac_init) begin
      fr2 <= rev2;
      fr3 <= rev3;
    end else if (cmd.frac_step) begin
      fr2 <= fb2 ? DW'(ft2 - {1'b0, den2}) : ft2[DW-1:0];
      fr3 <= fb3 ? DW'(ft3 - {1'b0, den3}) : ft3[DW-1:0];
      q2  <= {q2[FRAC_BITS-2:0], fb2};
      q3  <= {q3[FRAC_BITS-2:0], fb3};
    end
  end

  // output word register
  assign jx_full = JW'(q2) - HALF;
  assign jy_full = JW'(q3) - HALF;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      jitter_x      <= $signed(jx_full[hsj_pkg::JIT_W-1:0]);
      jitter_y      <= $signed(jy_full[hsj_pkg::JIT_W-1:0]);
      phase_total   <= hsj_pkg::PT_W'(phases);
      phase_clamped <= clamped;
    end
  end

endmodule

`default_nettype wire

### rtl/hsj_ctrl.sv
// controller: sequences phase count, modulo, digit and fraction steps and owns the handshakes
`default_nettype none

module hsj_ctrl #(
  parameter int FRAC_BITS = hsj_pkg::DEF_FRAC_BITS
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire                     out_stall,
  input  wire  hsj_pkg::hsj_sts_t sts,
  output hsj_pkg::hsj_cmd_t       cmd
);

  localparam int MAX_A   = (hsj_pkg::NUM_W > hsj_pkg::MOD_STEPS) ?
                           hsj_pkg::NUM_W : hsj_pkg::MOD_STEPS;
  localparam int MAX_CNT = (MAX_A > FRAC_BITS) ? MAX_A : FRAC_BITS;
  localparam int CNT_W   = $clog2(MAX_CNT + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQR   = 4'd1;
  localparam logic [3:0] S_PLOAD = 4'd2;
  localparam logic [3:0] S_PDIV  = 4'd3;
  localparam logic [3:0] S_PFIN  = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIG   = 4'd7;
  localparam logic [3:0] S_FRAC  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (sts.phase_ok) begin
            state_next = S_MOD;
            cnt_next   = CNT_W'(hsj_pkg::MOD_STEPS);
          end else begin
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        cmd.sq     = 1'b1;
        state_next = S_PLOAD;
      end
      S_PLOAD: begin
        cmd.pdiv_init = 1'b1;
        state_next    = S_PDIV;
        cnt_next      = CNT_W'(hsj_pkg::NUM_W);
      end
      S_PDIV: begin
        cmd.pdiv_step = 1'b1;
        cnt_next      = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          state_next = S_PFIN;
        end
      end
      S_PFIN: begin
        cmd.pdiv_fin = 1'b1;
        state_next   = S_MOD;
        cnt_next     = CNT_W'(hsj_pkg::MOD_STEPS);
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          state_next = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.dig_init = 1'b1;
        state_next   = S_DIG;
      end
      S_DIG: begin
        if (sts.dig_done) begin
          cmd.frac_init = 1'b1;
          state_next    = S_FRAC;
          cnt_next      = CNT_W'(FRAC_BITS);
        end else begin
          cmd.dig_step = 1'b1;
        end
      end
      S_FRAC: begin
        cmd.frac_step = 1'b1;
        cnt_next      = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output word overwritten while stalled");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  a_mod_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> sts.phase_ok)
    else $error("modulo step without a valid phase count");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the halton (2,3) sub-pixel jitter generator
`timescale 1ns / 100ps

module testbench;
  import hsj_pkg::*;

  localparam int        MAX_PH      = DEF_MAX_PHASES;
  localparam int        FRAC        = DEF_FRAC_BITS;
  localparam logic [63:0] HALF      = 64'd1 << (FRAC - 1);
  localparam int        STALL_PCT   = 20;
  localparam int        QUIET_LIMIT = 3000;
  localparam int        CALM_START  = 20000;
  localparam int        CALM_END    = 32000;
  localparam int        RAND_SETS   = 12;
  localparam int        WORDS_PER_SET = 80;
  localparam logic [FC_W-1:0] ALL_ONES = {FC_W{1'b1}};

  // one expected result word
  typedef struct {
    logic signed [JIT_W-1:0] jx;
    logic signed [JIT_W-1:0] jy;
    logic [PT_W-1:0]         pt;
    logic                    pc;
  } jitter_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RENDER_WIDTH;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FC_W-1:0]       frame_counter = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [JIT_W-1:0] jitter_x;
  logic signed [JIT_W-1:0] jitter_y;
  logic [PT_W-1:0]       phase_total;
  logic                  phase_clamped;

  // frames waiting to be sent and jitter results still owed by the block
  logic [FC_W-1:0] frame_queue[$];
  jitter_t         jitter_due[$];
  jitter_t         want;

  // width registers as the block should hold them
  logic [CFG_W-1:0] render_w = WIDTH_RESET;
  logic [CFG_W-1:0] display_w = WIDTH_RESET;

  int words_left = 0;
  int errors = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int clamped_seen = 0;
  int width_sets = 1;
  int cyc = 0;
  int quiet_cycles = 0;
  bit calm;

  halton_subpixel_jitter uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_counter(frame_counter),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .jitter_x(jitter_x),
    .jitter_y(jitter_y),
    .phase_total(phase_total),
    .phase_clamped(phase_clamped)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  // floor(radical inverse of n in the given base, scaled by 2^FRAC)
  function automatic logic [63:0] radical_fixed(input logic [63:0] n, input logic [63:0] base);
    logic [63:0] rev;
    logic [63:0] den;
    logic [63:0] rest;
    rev = 0;
    den = 1;
    rest = n;
    while (rest > 0) begin
      rev = rev * base + (rest % base);
      rest = rest / base;
      den = den * base;
    end
    return (rev << FRAC) / den;
  endfunction

  // jitter for one frame under the given widths
  function automatic jitter_t predict_jitter(input logic [FC_W-1:0] frame,
                                             input logic [CFG_W-1:0] rw,
                                             input logic [CFG_W-1:0] dw);
    jitter_t     r;
    logic [63:0] rsq;
    logic [63:0] num;
    logic [63:0] phases;
    logic [63:0] idx;
    logic        clamp;
    clamp = 1'b0;
    if (rw == 0) begin
      // unbounded ratio
      phases = MAX_PH;
      clamp = 1'b1;
    end else begin
      rsq = 64'(rw) * 64'(rw);
      num = 64'd8 * 64'(dw) * 64'(dw);
      phases = (num + rsq - 1) / rsq;
      if (phases > MAX_PH) begin
        phases = MAX_PH;
        clamp = 1'b1;
      end
      if (phases == 0) phases = 1;
    end
    idx = (frame % phases) + 1;
    r.jx = JIT_W'(radical_fixed(idx, 64'd2) - HALF);
    r.jy = JIT_W'(radical_fixed(idx, 64'd3) - HALF);
    r.pt = PT_W'(phases);
    r.pc = clamp;
    return r;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic queue_frame(input logic [FC_W-1:0] f);
    frame_queue.push_back(f);
    words_left++;
  endtask

  // wait until every word is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk); while (words_left != 0 || jitter_due.size() != 0);
  endtask

  // write render then display width, valid held across both words
  task automatic set_widths(input logic [CFG_W-1:0] rw, input logic [CFG_W-1:0] dw);
    wait_drained();
    cfg_index <= CFG_RENDER_WIDTH;
    cfg_data <= rw;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    render_w = rw;
    cfg_index <= CFG_DISPLAY_WIDTH;
    cfg_data <= dw;
    do @(posedge clk); while (!cfg_ready);
    display_w = dw;
    cfg_valid <= 1'b0;
    width_sets++;
  endtask

  function automatic logic [FC_W-1:0] rand_frame();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return {$urandom, $urandom};
      5, 6:          return FC_W'($urandom_range(0, 1023));
      7:             return ALL_ONES - FC_W'($urandom_range(0, 600));
      default:       return {$urandom, $urandom} & {2{$urandom}};
    endcase
  endfunction

  // input driver: one word held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        jitter_due.push_back(predict_jitter(frame_counter, render_w, display_w));
        words_left--;
        frames_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (frame_queue.size() > 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          frame_counter <= frame_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (phase_clamped) clamped_seen++;
        if (jitter_due.size() == 0) begin
          $display("%0t: result word with nothing expected, jitter_x %0d jitter_y %0d",
                   $time, jitter_x, jitter_y);
          errors++;
        end else begin
          want = jitter_due.pop_front();
          check_field("jitter_x", want.jx, jitter_x);
          check_field("jitter_y", want.jy, jitter_y);
          check_field("phase_total", want.pt, phase_total);
          check_field("phase_clamped", want.pc, phase_clamped);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    cyc++;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, jitter_due.size());
      $display("** halton_subpixel_jitter: FAILED **");
      $finish;
    end
  end

  // stimulus
  initial begin
    int   rw;
    int   dw;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset widths give eight phases
    queue_frame(64'd0);
    queue_frame(64'd1);
    queue_frame(64'd7);
    queue_frame(64'd8);
    queue_frame(ALL_ONES);
    queue_frame({16{4'hA}});
    queue_frame({16{4'h5}});

    // exactly 256 phases, not clamped
    set_widths(15'd99, 15'd560);
    queue_frame(64'd255);
    queue_frame(64'd256);
    queue_frame(64'd511);

    // 257 computed, clamped to 256
    set_widths(15'd99, 15'd561);
    queue_frame(64'd255);
    queue_frame(ALL_ONES);

    // zero render width
    set_widths(15'd0, 15'd16384);
    queue_frame(64'd254);
    queue_frame(64'd3);

    // zero display width: count raised to one
    set_widths(15'h7FFF, 15'd0);
    queue_frame(ALL_ONES);
    queue_frame(64'd12345);

    // huge ratio: index 243 is the first with six base 3 digits, 128 the first with eight base 2 digits
    set_widths(15'd1, 15'h7FFF);
    queue_frame(64'd242);
    queue_frame(64'd127);

    // equal max widths, and a ratio far below one
    set_widths(15'h7FFF, 15'h7FFF);
    queue_frame(64'd6);
    set_widths(15'd16384, 15'd1);
    queue_frame(64'd9);

    // random width settings with random frames
    for (int s = 0; s < RAND_SETS; s++) begin
      case ($urandom_range(9))
        0: begin
          rw = 0;
          dw = $urandom_range(0, 32767);
        end
        1: begin
          rw = $urandom_range(1, 32767);
          dw = 0;
        end
        2: begin
          rw = $urandom_range(1, 8);
          dw = $urandom_range(1, 32767);
        end
        3: begin
          rw = $urandom_range(1, 32767);
          dw = $urandom_range(1, rw);
        end
        default: begin
          rw = $urandom_range(1, 16384);
          dw = (rw * $urandom_range(20, 60)) / 10;
          if (dw > 32767) dw = 32767;
        end
      endcase
      set_widths(CFG_W'(rw), CFG_W'(dw));
      for (int i = 0; i < WORDS_PER_SET; i++) queue_frame(rand_frame());
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("sent %0d frames over %0d width settings", frames_sent, width_sets);
    $display("checked %0d result words, %0d with the phase clamp set",
             results_seen, clamped_seen);
    if (errors == 0) begin
      $display("** halton_subpixel_jitter: PASSED **");
    end else begin
      $display("** halton_subpixel_jitter: FAILED **");
    end
    $finish;
  end

endmodule

### halton_subpixel_jitter.f
rtl/hsj_pkg.sv
rtl/hsj_dp.sv
rtl/hsj_ctrl.sv
rtl/halton_subpixel_jitter.sv
verif/testbench.sv
